/* rtl/rxrs_pkg.sv */
// ---------------------------------------------------------------------------
// rxrs_pkg
// Shared types and constants for the range xor / range sum store.
// ---------------------------------------------------------------------------
package rxrs_pkg;

	// fixed field widths
	localparam int POS_W   = 11;
	localparam int OPND_W  = 21;
	localparam int SUM_W   = 31;
	localparam int CMD_W   = 2;

	// defaults for the top-level parameters
	localparam int DEF_SIZE       = 1024;
	localparam int DEF_VALUE_BITS = 21;

	// reset value of the element count register
	localparam logic [POS_W-1:0] COUNT_RESET = POS_W'(1024);

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD = 2'd0,
		CMD_SUM  = 2'd1,
		CMD_XOR  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// finished sum handed from the sequencer to the output stage
	typedef struct packed {
		logic             valid;
		logic [SUM_W-1:0] sum;
	} res_t;

endpackage

/* rtl/rxrs_if.sv */
// ---------------------------------------------------------------------------
// rxrs_if
// Valid/ready channel interfaces: command, result and count write.
// ---------------------------------------------------------------------------
interface rxrs_req_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  command;
	logic [rxrs_pkg::POS_W-1:0]  left_pos;
	logic [rxrs_pkg::POS_W-1:0]  right_pos;
	logic [rxrs_pkg::OPND_W-1:0] operand_value;
	modport source (output valid, command, left_pos, right_pos, operand_value, input ready);
	modport sink   (input valid, command, left_pos, right_pos, operand_value, output ready);
endinterface

interface rxrs_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [rxrs_pkg::SUM_W-1:0] range_sum;
	modport source (output valid, range_sum, input ready);
	modport sink   (input valid, range_sum, output ready);
endinterface

interface rxrs_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [rxrs_pkg::POS_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

/* rtl/range_xor_range_sum_store.sv */
// ---------------------------------------------------------------------------
// range_xor_range_sum_store
// Element store with load, range xor and range sum commands.
//
//   channel  dir  beat
//   req      in   command, left_pos, right_pos, operand_value
//   rsp      out  range_sum (sum commands only)
//   cfg      in   element_count
//
// Load and unknown commands complete in idle. A range (after clipping) is
// walked one element per cycle through the single memory read port, then
// drained, and a sum is then handed to the output register. An empty sum
// goes straight to the hand-over. arst_n clears control and sets the count
// to 1024; memory contents are left as they are. A stalled rsp holds one
// sum in the output register and the next in the sequencer; req waits.
// ---------------------------------------------------------------------------
module range_xor_range_sum_store #(
	parameter int SIZE       = rxrs_pkg::DEF_SIZE,
	parameter int VALUE_BITS = rxrs_pkg::DEF_VALUE_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	rxrs_req_if.sink  req,
	rxrs_rsp_if.source rsp,
	rxrs_cfg_if.sink  cfg
);
	import rxrs_pkg::*;

	logic [POS_W-1:0] count_q;
	logic             out_valid_q;
	logic [SUM_W-1:0] out_sum_q;
	res_t             res;
	logic             res_ready;

	// count register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg.valid) begin
			count_q <= cfg.data;
		end
	end

	// output register
	assign res_ready = !out_valid_q || rsp.ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			out_sum_q <= res.sum;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.range_sum = out_sum_q;

	rxrs_ctrl #(
		.SIZE       (SIZE),
		.VALUE_BITS (VALUE_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.element_count (count_q),
		.req           (req),
		.res           (res),
		.res_ready     (res_ready)
	);

endmodule

/* rtl/rxrs_mem.sv */
// ---------------------------------------------------------------------------
// rxrs_mem
// Element memory: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module rxrs_mem #(
	parameter int SIZE       = 1024,
	parameter int VALUE_BITS = 21
) (
	input  logic                    clk,
	input  logic                    re,
	input  logic [$clog2(SIZE)-1:0] raddr,
	output logic [VALUE_BITS-1:0]   rdata,
	input  logic                    we,
	input  logic [$clog2(SIZE)-1:0] waddr,
	input  logic [VALUE_BITS-1:0]   wdata
);
	logic [VALUE_BITS-1:0] mem_q [SIZE];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/rxrs_ctrl.sv */
// ---------------------------------------------------------------------------
// rxrs_ctrl
// Command sequencer: clips the range, walks it one element per cycle with
// read-modify-write for xor and an accumulator for sum.
// ---------------------------------------------------------------------------
module rxrs_ctrl #(
	parameter int SIZE       = 1024,
	parameter int VALUE_BITS = 21
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [rxrs_pkg::POS_W-1:0]    element_count,
	rxrs_req_if.sink                      req,
	output rxrs_pkg::res_t                res,
	input  logic                          res_ready
);
	import rxrs_pkg::*;

	localparam int AW = $clog2(SIZE);

	state_t                state_q, state_d;
	logic [AW-1:0]         addr_q, last_q;
	logic                  is_sum_q;
	logic [VALUE_BITS-1:0] mask_q;
	logic [SUM_W-1:0]      acc_q;
	logic                  rd_valid_s1;
	logic [AW-1:0]         rd_addr_s1;

	logic                  fire;
	logic [31:0]           cnt, lo_c, hi_c;
	logic                  empty;
	logic                  load_ok;
	logic                  re, we;
	logic [AW-1:0]         waddr;
	logic [VALUE_BITS-1:0] wdata, rdata, opnd;

	// clipping of the range against the count in use
	always_comb begin
		cnt     = (32'(element_count) > 32'(SIZE)) ? 32'(SIZE) : 32'(element_count);
		lo_c    = (req.left_pos == '0) ? 32'd1 : 32'(req.left_pos);
		hi_c    = (32'(req.right_pos) > cnt) ? cnt : 32'(req.right_pos);
		empty   = lo_c > hi_c;
		load_ok = (req.left_pos != '0) && (32'(req.left_pos) <= cnt);
		opnd    = VALUE_BITS'(req.operand_value);
	end

	assign req.ready = (state_q == ST_IDLE);
	assign fire      = req.valid && req.ready;

	// next state
	always_comb begin
		state_d   = state_q;
		res.valid = 1'b0;
		res.sum   = acc_q;
		unique case (state_q)
			ST_IDLE: begin
				if (fire) begin
					unique case (req.command)
						CMD_SUM:  state_d = empty ? ST_FINISH : ST_WALK;
						CMD_XOR:  state_d = empty ? ST_IDLE : ST_WALK;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_WALK: begin
				if (addr_q == last_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = is_sum_q ? ST_FINISH : ST_IDLE;
			end
			ST_FINISH: begin
				res.valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// memory port selection: load in idle, write-back while walking and draining
	always_comb begin
		re    = (state_q == ST_WALK);
		we    = 1'b0;
		waddr = rd_addr_s1;
		wdata = rdata ^ mask_q;
		if (fire && req.command == CMD_LOAD && load_ok) begin
			we    = 1'b1;
			waddr = AW'(32'(req.left_pos) - 32'd1);
			wdata = opnd;
		end else if (rd_valid_s1 && !is_sum_q) begin
			we = 1'b1;
		end
	end

	// read pipeline valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == ST_WALK);
		end
	end

	// walk registers and accumulator
	always_ff @(posedge clk) begin
		rd_addr_s1 <= addr_q;
		if (fire) begin
			addr_q   <= AW'(lo_c - 32'd1);
			last_q   <= AW'(hi_c - 32'd1);
			is_sum_q <= (req.command == CMD_SUM);
			mask_q   <= opnd;
			acc_q    <= '0;
		end else begin
			if (state_q == ST_WALK) begin
				addr_q <= addr_q + AW'(1);
			end
			if (rd_valid_s1 && is_sum_q) begin
				acc_q <= acc_q + SUM_W'(rdata);
			end
		end
	end

	rxrs_mem #(
		.SIZE       (SIZE),
		.VALUE_BITS (VALUE_BITS)
	) u_mem (
		.clk   (clk),
		.re    (re),
		.raddr (addr_q),
		.rdata (rdata),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata)
	);

	// read data only returns for a read issued while walking
	a_rd_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> $past(state_q == ST_WALK))
		else $error("read beat without walk");

	// no memory write while a result is held
	a_no_write_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> !we)
		else $error("write during finish");

	// a sum only leaves after its range has drained, or straight from idle when empty
	a_finish_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_FINISH) |-> ($past(state_q == ST_DRAIN) || $past(fire)))
		else $error("finish entered from wrong state");

endmodule
